### rtl/idrm_pkg.sv
// shared types and constants of the impulse detector
`default_nettype none

package idrm_pkg;

   // field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int E_W        = 31;
   localparam int LEVEL_W    = 31;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int RSP_W      = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RMS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EGAIN = 2'd2;

   // register reset values
   localparam logic [LEVEL_W-1:0] LEVEL_RST = 31'd1000000;
   localparam logic [GAIN_W-1:0]  RMS_RST   = 16'd4096;
   localparam logic [GAIN_W-1:0]  EGAIN_RST = 16'd512;

   // shift-add product of the rms criterion
   localparam int MUL_STEPS = 17;
   localparam int MCNT_W    = 5;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic col_start;
      logic col_run;
      logic col_end;
      logic scan_start;
      logic scan_run;
      logic psq;
      logic mul_start;
      logic mul_run;
      logic med_start;
      logic cand_rd;
      logic cand_lat;
      logic inner_run;
      logic med_next;
      logic gain_mul;
   } idrm_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic tap_last;
      logic win_full;
      logic col_done;
      logic scan_done;
      logic crit1_ok;
      logic mul_done;
      logic crit2_ok;
      logic inner_done;
      logic med_found;
      logic med_b;
      logic det_ok;
   } idrm_sts_type;

endpackage

`default_nettype wire

### rtl/idrm_dp.sv
// datapath: energy ring, sorted columns, peak scan, criteria arithmetic
`default_nettype none

module idrm_dp import idrm_pkg::*; #(
   parameter int TAP_LENGTH = 32,
   parameter int TAP_DEPTH  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [SAMPLE_W-1:0]   req_sample,
   input  wire idrm_cmd_type                 cmd,
   output idrm_sts_type                      sts,
   input  wire logic                         csr_valid,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int OFF_W  = $clog2(TAP_LENGTH);
   localparam int SLOT_W = $clog2(TAP_DEPTH);
   localparam int DCNT_W = $clog2(TAP_DEPTH + 1);
   localparam int LCNT_W = $clog2(TAP_LENGTH + 1);
   localparam int MID    = TAP_DEPTH / 2;
   localparam int KMED   = TAP_LENGTH / 2;
   localparam int SUM_W  = 61 + $clog2(TAP_LENGTH);
   localparam int WIDE_W = SUM_W + MUL_STEPS;
   localparam logic [MUL_STEPS-1:0] LHS_K = MUL_STEPS'(TAP_LENGTH * 256);

   // memories
   logic [E_W-1:0] ring_mem [TAP_DEPTH][TAP_LENGTH];
   logic [E_W-1:0] col_mem  [TAP_LENGTH][TAP_DEPTH];
   logic [E_W-1:0] ring_rd_ff, col_rd_ff;
   logic              ring_re, ring_we, col_re, col_we;
   logic [SLOT_W-1:0] ring_rs, col_rc, col_wc;
   logic [OFF_W-1:0]  ring_ro, col_ro;
   logic [E_W-1:0]    col_wd;

   // tap bookkeeping
   logic [E_W-1:0]    energy_ff, energy_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [DCNT_W-1:0] taps_ff, taps_in;

   // column pass
   logic [DCNT_W-1:0] r_ff, r_in, w_ff, w_in, nread_ff, nread_in;
   logic              cp_ff, cp_in, del_ff, del_in, ins_ff, ins_in;
   logic [SLOT_W-1:0] cpidx_ff, cpidx_in;
   logic [E_W-1:0]    hold_ff, hold_in;

   // peak scan
   logic [LCNT_W-1:0] si_ff, si_in;
   logic              s1_ff, s1_in, s2_ff, s2_in;
   logic [OFF_W-1:0]  s1idx_ff, s1idx_in, pos_ff, pos_in;
   logic [E_W-1:0]    peak_ff, peak_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // products
   logic [E_W-1:0]         mul_a, mul_b;
   logic [2*E_W-1:0]       prod_ff;
   logic [WIDE_W-1:0]      lm_ff, lm_in, rm_ff, rm_in, lacc_ff, lacc_in, racc_ff, racc_in;
   logic [MUL_STEPS-1:0]   kb_ff, kb_in, rb_ff, rb_in;
   logic [MCNT_W-1:0]      mcnt_ff, mcnt_in;

   // median selection
   logic              medsel_ff, medsel_in, mp_ff, mp_in;
   logic [OFF_W-1:0]  ci_ff, ci_in;
   logic [LCNT_W-1:0] j_ff, j_in, lt_ff, lt_in, le_ff, le_in;
   logic [E_W-1:0]    cand_ff, cand_in, meda_ff, meda_in, medb_ff, medb_in;

   // configuration
   logic [LEVEL_W-1:0] level_ff;
   logic [GAIN_W-1:0]  rmsg_ff, egain_ff;

   // helpers
   logic [SAMPLE_W-1:0] mag;
   logic [2*SAMPLE_W-1:0] sq;
   logic                full_c;
   logic [SLOT_W-1:0]   slot_c, mid_slot, mslot, mage;
   logic [OFF_W-1:0]    idx, moff;
   logic [OFF_W:0]      psum;
   logic                wrap;
   logic [E_W-1:0]      v, e_nz;

   // slot of a tap by its age from the oldest
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] nw,
                                                 input logic [SLOT_W-1:0] age);
      logic [SLOT_W:0] s;
      s = {1'b0, nw} + {1'b0, age} + (SLOT_W+1)'(1);
      if (s >= (SLOT_W+1)'(TAP_DEPTH)) s = s - (SLOT_W+1)'(TAP_DEPTH);
      return s[SLOT_W-1:0];
   endfunction

   // sample energy
   assign mag = req_sample[SAMPLE_W-1] ? (~req_sample + 16'd1) : req_sample;
   assign sq  = {16'd0, mag} * {16'd0, mag};

   assign full_c   = (taps_ff == DCNT_W'(TAP_DEPTH));
   assign slot_c   = (taps_ff == '0) ? '0 : slot_of(newest_ff, '0);
   assign mid_slot = slot_of(newest_ff, SLOT_W'(MID));

   // window addressing for the medians
   assign idx  = cmd.cand_rd ? ci_ff : j_ff[OFF_W-1:0];
   assign psum = {1'b0, pos_ff} + {1'b0, idx};
   assign wrap = (psum >= (OFF_W+1)'(TAP_LENGTH));
   assign moff = wrap ? OFF_W'(psum - (OFF_W+1)'(TAP_LENGTH)) : psum[OFF_W-1:0];
   assign mage = (medsel_ff ? SLOT_W'(MID) : SLOT_W'(MID - 1)) + SLOT_W'(wrap);
   assign mslot = slot_of(newest_ff, mage);

   // memory access selection
   always_comb begin
      ring_re = cmd.col_start | (cmd.scan_run & (si_ff < LCNT_W'(TAP_LENGTH))) |
                cmd.cand_rd | (cmd.inner_run & (j_ff < LCNT_W'(TAP_LENGTH)));
      ring_we = cmd.col_start;
      if (cmd.col_start) begin
         ring_rs = slot_c;
         ring_ro = off_ff;
      end else if (cmd.scan_run) begin
         ring_rs = mid_slot;
         ring_ro = si_ff[OFF_W-1:0];
      end else begin
         ring_rs = mslot;
         ring_ro = moff;
      end
      col_re = (cmd.col_run & (r_ff < nread_ff)) |
               (cmd.scan_run & (si_ff < LCNT_W'(TAP_LENGTH)));
      if (cmd.col_run) begin
         col_ro = off_ff;
         col_rc = r_ff[SLOT_W-1:0];
      end else begin
         col_ro = si_ff[OFF_W-1:0];
         col_rc = SLOT_W'(MID);
      end
   end

   // shared multiplier operands
   always_comb begin
      if (cmd.psq) begin
         mul_a = peak_ff;
         mul_b = peak_ff;
      end else if (cmd.gain_mul) begin
         mul_a = meda_ff;
         mul_b = E_W'(egain_ff);
      end else begin
         mul_a = col_rd_ff;
         mul_b = col_rd_ff;
      end
   end

   assign v    = col_rd_ff;
   assign e_nz = (ring_rd_ff > col_rd_ff) ? ring_rd_ff - col_rd_ff : '0;

   // next-state logic
   always_comb begin
      energy_in = energy_ff;  off_in = off_ff;  newest_in = newest_ff;  taps_in = taps_ff;
      r_in = r_ff;  w_in = w_ff;  nread_in = nread_ff;  cp_in = 1'b0;  cpidx_in = cpidx_ff;
      del_in = del_ff;  ins_in = ins_ff;  hold_in = hold_ff;
      si_in = si_ff;  s1_in = 1'b0;  s2_in = 1'b0;  s1idx_in = s1idx_ff;
      peak_in = peak_ff;  pos_in = pos_ff;  sum_in = sum_ff;
      lm_in = lm_ff;  rm_in = rm_ff;  lacc_in = lacc_ff;  racc_in = racc_ff;
      kb_in = kb_ff;  rb_in = rb_ff;  mcnt_in = mcnt_ff;
      medsel_in = medsel_ff;  ci_in = ci_ff;  j_in = j_ff;  mp_in = 1'b0;
      lt_in = lt_ff;  le_in = le_ff;  cand_in = cand_ff;  meda_in = meda_ff;  medb_in = medb_ff;
      col_we = 1'b0;  col_wc = w_ff[SLOT_W-1:0];  col_wd = energy_ff;

      if (cmd.load) energy_in = sq[E_W-1:0];

      // column pass setup
      if (cmd.col_start) begin
         r_in = '0;  w_in = '0;  del_in = 1'b0;  ins_in = 1'b0;
         nread_in = full_c ? DCNT_W'(TAP_DEPTH) : taps_ff;
      end

      // column merge: drop the old energy once, insert the new one in order
      if (cmd.col_run) begin
         if (r_ff < nread_ff) begin
            r_in = r_ff + 1'b1;
            cp_in = 1'b1;
            cpidx_in = r_ff[SLOT_W-1:0];
         end
         if (cp_ff) begin
            if (full_c && !del_ff &&
                (v == ring_rd_ff || cpidx_ff == SLOT_W'(TAP_DEPTH - 1))) begin
               del_in = 1'b1;
            end else begin
               col_we = 1'b1;
               w_in = w_ff + 1'b1;
               if (ins_ff) begin
                  col_wd = hold_ff;
                  hold_in = v;
               end else if (v > energy_ff) begin
                  col_wd = energy_ff;
                  hold_in = v;
                  ins_in = 1'b1;
               end else begin
                  col_wd = v;
               end
            end
         end
      end

      // last column write and tap bookkeeping
      if (cmd.col_end) begin
         col_we = 1'b1;
         col_wd = ins_ff ? hold_ff : energy_ff;
         if (off_ff == OFF_W'(TAP_LENGTH - 1)) begin
            off_in = '0;
            newest_in = slot_c;
            if (!full_c) taps_in = taps_ff + 1'b1;
         end else begin
            off_in = off_ff + 1'b1;
         end
      end

      // peak scan and noise energy sum
      if (cmd.scan_start) begin
         si_in = '0;  peak_in = '0;  pos_in = '0;  sum_in = '0;
      end
      if (cmd.scan_run) begin
         if (si_ff < LCNT_W'(TAP_LENGTH)) begin
            si_in = si_ff + 1'b1;
            s1_in = 1'b1;
            s1idx_in = si_ff[OFF_W-1:0];
         end
         if (s1_ff) begin
            s2_in = 1'b1;
            if (e_nz > peak_ff) begin
               peak_in = e_nz;
               pos_in = s1idx_ff;
            end
         end
         if (s2_ff) sum_in = sum_ff + SUM_W'(prod_ff);
      end

      // shift-add products of the rms criterion
      if (cmd.mul_start) begin
         lm_in = WIDE_W'(prod_ff);
         rm_in = WIDE_W'(sum_ff);
         kb_in = LHS_K;
         rb_in = {1'b0, rmsg_ff};
         lacc_in = '0;  racc_in = '0;  mcnt_in = '0;
      end
      if (cmd.mul_run) begin
         if (kb_ff[0]) lacc_in = lacc_ff + lm_ff;
         if (rb_ff[0]) racc_in = racc_ff + rm_ff;
         lm_in = {lm_ff[WIDE_W-2:0], 1'b0};
         rm_in = {rm_ff[WIDE_W-2:0], 1'b0};
         kb_in = {1'b0, kb_ff[MUL_STEPS-1:1]};
         rb_in = {1'b0, rb_ff[MUL_STEPS-1:1]};
         mcnt_in = mcnt_ff + 1'b1;
      end

      // median by rank counting
      if (cmd.med_start) begin
         medsel_in = 1'b0;
         ci_in = '0;
      end
      if (cmd.cand_lat) begin
         cand_in = ring_rd_ff;
         lt_in = '0;  le_in = '0;  j_in = '0;
      end
      if (cmd.inner_run) begin
         if (j_ff < LCNT_W'(TAP_LENGTH)) begin
            j_in = j_ff + 1'b1;
            mp_in = 1'b1;
         end
         if (mp_ff) begin
            if (ring_rd_ff < cand_ff) lt_in = lt_ff + 1'b1;
            if (ring_rd_ff <= cand_ff) le_in = le_ff + 1'b1;
         end
      end
      if (cmd.med_next) begin
         if (sts.med_found) begin
            if (medsel_ff) begin
               medb_in = cand_ff;
            end else begin
               meda_in = cand_ff;
               medsel_in = 1'b1;
               ci_in = '0;
            end
         end else begin
            ci_in = ci_ff + 1'b1;
         end
      end
   end

   // status
   always_comb begin
      sts.tap_last   = (off_ff == OFF_W'(TAP_LENGTH - 1));
      sts.win_full   = (taps_ff >= DCNT_W'(TAP_DEPTH - 1));
      sts.col_done   = (r_ff == nread_ff) && !cp_ff;
      sts.scan_done  = (si_ff == LCNT_W'(TAP_LENGTH)) && !s1_ff && !s2_ff;
      sts.crit1_ok   = (peak_ff > level_ff);
      sts.mul_done   = (mcnt_ff == MCNT_W'(MUL_STEPS));
      sts.crit2_ok   = (lacc_ff > racc_ff);
      sts.inner_done = (j_ff == LCNT_W'(TAP_LENGTH)) && !mp_ff;
      sts.med_found  = (lt_ff <= LCNT_W'(KMED)) && (le_ff > LCNT_W'(KMED));
      sts.med_b      = medsel_ff;
      sts.det_ok     = ((2*E_W)'({medb_ff, 8'd0}) > prod_ff);
   end

   // energy ring, read before write
   always_ff @(posedge clock) begin
      if (ring_re) ring_rd_ff <= ring_mem[ring_rs][ring_ro];
      if (ring_we) ring_mem[slot_c][off_ff] <= energy_ff;
   end

   // sorted columns, read before write
   always_ff @(posedge clock) begin
      if (col_re) col_rd_ff <= col_mem[col_ro][col_rc];
      if (col_we) col_mem[off_ff][col_wc] <= col_wd;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0;  newest_ff <= '0;  taps_ff <= '0;
         cp_ff <= 1'b0;  s1_ff <= 1'b0;  s2_ff <= 1'b0;  mp_ff <= 1'b0;
         level_ff <= LEVEL_RST;  rmsg_ff <= RMS_RST;  egain_ff <= EGAIN_RST;
      end else begin
         off_ff <= off_in;  newest_ff <= newest_in;  taps_ff <= taps_in;
         cp_ff <= cp_in;  s1_ff <= s1_in;  s2_ff <= s2_in;  mp_ff <= mp_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_LEVEL: level_ff <= csr_data[LEVEL_W-1:0];
               CSR_RMS:   rmsg_ff  <= csr_data[GAIN_W-1:0];
               CSR_EGAIN: egain_ff <= csr_data[GAIN_W-1:0];
               default:   ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      r_ff <= r_in;  w_ff <= w_in;  nread_ff <= nread_in;  cpidx_ff <= cpidx_in;
      del_ff <= del_in;  ins_ff <= ins_in;  hold_ff <= hold_in;
      si_ff <= si_in;  s1idx_ff <= s1idx_in;  peak_ff <= peak_in;  pos_ff <= pos_in;
      sum_ff <= sum_in;
      prod_ff <= {{E_W{1'b0}}, mul_a} * {{E_W{1'b0}}, mul_b};
      lm_ff <= lm_in;  rm_ff <= rm_in;  lacc_ff <= lacc_in;  racc_ff <= racc_in;
      kb_ff <= kb_in;  rb_ff <= rb_in;  mcnt_ff <= mcnt_in;
      medsel_ff <= medsel_in;  ci_ff <= ci_in;  j_ff <= j_in;
      lt_ff <= lt_in;  le_ff <= le_in;  cand_ff <= cand_in;
      meda_ff <= meda_in;  medb_ff <= medb_in;
   end

endmodule

`default_nettype wire

### rtl/idrm_ctrl.sv
// controller state machine and result register
`default_nettype none

module idrm_ctrl import idrm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,
   output idrm_cmd_type            cmd,
   input  wire idrm_sts_type       sts
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDOLD  = 4'd1;
   localparam logic [3:0] S_COL    = 4'd2;
   localparam logic [3:0] S_COLEND = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_PSQ    = 4'd5;
   localparam logic [3:0] S_MST    = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_MCAND  = 4'd8;
   localparam logic [3:0] S_MLAT   = 4'd9;
   localparam logic [3:0] S_MIN    = 4'd10;
   localparam logic [3:0] S_MCHK   = 4'd11;
   localparam logic [3:0] S_G1     = 4'd12;
   localparam logic [3:0] S_G2     = 4'd13;
   localparam logic [3:0] S_EMIT   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       res_det_ff, res_det_in, res_full_ff, res_full_in;
   logic       rsp_valid_ff, rsp_valid_in, rsp_det_ff, rsp_det_in, rsp_full_ff, rsp_full_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-2){1'b0}}, rsp_full_ff, rsp_det_ff};

   // sequencing
   always_comb begin
      state_in = state_ff;
      res_det_in = res_det_ff;
      res_full_in = res_full_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_det_in = rsp_det_ff;
      rsp_full_in = rsp_full_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_RDOLD;
            end
         end
         S_RDOLD: begin
            cmd.col_start = 1'b1;
            state_in = S_COL;
         end
         S_COL: begin
            if (sts.col_done) state_in = S_COLEND;
            else cmd.col_run = 1'b1;
         end
         S_COLEND: begin
            cmd.col_end = 1'b1;
            if (sts.tap_last && sts.win_full) begin
               cmd.scan_start = 1'b1;
               state_in = S_SCAN;
            end else if (sts.tap_last) begin
               res_det_in = 1'b0;
               res_full_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) state_in = S_PSQ;
         end
         S_PSQ: begin
            cmd.psq = 1'b1;
            res_full_in = 1'b1;
            res_det_in = 1'b0;
            state_in = sts.crit1_ok ? S_MST : S_EMIT;
         end
         S_MST: begin
            cmd.mul_start = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (sts.mul_done) begin
               if (sts.crit2_ok) begin
                  cmd.med_start = 1'b1;
                  state_in = S_MCAND;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               cmd.mul_run = 1'b1;
            end
         end
         S_MCAND: begin
            cmd.cand_rd = 1'b1;
            state_in = S_MLAT;
         end
         S_MLAT: begin
            cmd.cand_lat = 1'b1;
            state_in = S_MIN;
         end
         S_MIN: begin
            cmd.inner_run = 1'b1;
            if (sts.inner_done) state_in = S_MCHK;
         end
         S_MCHK: begin
            cmd.med_next = 1'b1;
            state_in = (sts.med_found && sts.med_b) ? S_G1 : S_MCAND;
         end
         S_G1: begin
            cmd.gain_mul = 1'b1;
            state_in = S_G2;
         end
         S_G2: begin
            res_det_in = sts.det_ok;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_det_in = res_det_ff;
               rsp_full_in = res_full_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_det_ff <= res_det_in;
      res_full_ff <= res_full_in;
      rsp_det_ff <= rsp_det_in;
      rsp_full_ff <= rsp_full_in;
   end

endmodule

`default_nettype wire

### rtl/impulse_detector_running_median_top.sv
// top level of the impulse detector with running-median noise floor
//
//   channel  direction  payload
//   req      in         tdata[15:0] sample (signed)
//   rsp      out        tdata[0] detected, tdata[1] window_full, tdata[7:2] zero
//   csr      in         csr_index register, csr_data value (always ready)
//
// a sample's time is set by the column merge pass through the sorted-column memory,
// one entry a cycle.
// the sample that completes a full window adds a peak scan and, as the criteria pass,
// a shift-add product and median rank counting over the single energy ring read port.
// reset clears tap count, offset and control registers; memories need no clearing pass.
// a result waiting on rsp does not stall new samples until the next result.
`default_nettype none

module impulse_detector_running_median_top import idrm_pkg::*; #(
   parameter int TAP_LENGTH = 32,
   parameter int TAP_DEPTH  = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic signed [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata,   // [0] detected, [1] window_full
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_data
);

   idrm_cmd_type cmd;
   idrm_sts_type sts;

   assign csr_ready = 1'b1;

   // controller
   idrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath
   idrm_dp #(
      .TAP_LENGTH (TAP_LENGTH),
      .TAP_DEPTH  (TAP_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // the block is not ready again in the cycle after it takes a sample
   ap_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sample taken while previous one in work");

   // detection only on a full window
   ap_det_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[1]))
      else $error("detected without full window");

   // padding bits stay zero
   ap_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_W-1:2] == '0))
      else $error("nonzero result padding");

endmodule

`default_nettype wire
